### sv/dstu_pkg.sv
// ----------------------------------------------------------------------------
// dstu_pkg
// Shared types and constants for the decimal string to u64 parser.
// ----------------------------------------------------------------------------
package dstu_pkg;

    typedef logic [1:0] t_phase;

    localparam t_phase PH_LEAD  = 2'd0;
    localparam t_phase PH_DIGIT = 2'd1;
    localparam t_phase PH_TRAIL = 2'd2;
    localparam t_phase PH_FAIL  = 2'd3;

    localparam int unsigned ACC_W = 64;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char;

    typedef struct packed {
        logic             ok;
        logic [ACC_W-1:0] number;
    } t_result;

endpackage

### sv/dstu_pipe_reg.sv
// ----------------------------------------------------------------------------
// dstu_pipe_reg
// One-entry valid/ready register stage; takes a new transfer while the held
// one leaves.
// ----------------------------------------------------------------------------
module dstu_pipe_reg #(
    parameter int unsigned WIDTH = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

### sv/dstu_parse.sv
// ----------------------------------------------------------------------------
// dstu_parse
// Phase and accumulator registers with the per-character update:
// classify, multiply by ten plus digit, carry check, result on last.
// ----------------------------------------------------------------------------
module dstu_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  dstu_pkg::t_char   i_char,
    output dstu_pkg::t_result o_result
);

    localparam int unsigned WIDE_W = dstu_pkg::ACC_W + 4;

    dstu_pkg::t_phase              r_phase;
    logic [dstu_pkg::ACC_W-1:0]    r_acc;
    dstu_pkg::t_phase              n_phase;
    logic [dstu_pkg::ACC_W-1:0]    n_acc;
    dstu_pkg::t_phase              upd_phase;
    logic [dstu_pkg::ACC_W-1:0]    upd_acc;
    logic                          is_dig;
    logic                          is_ws;
    logic [3:0]                    digit;
    logic [WIDE_W-1:0]             wide;
    logic                          ovf;

    assign is_dig = (i_char.code >= dstu_pkg::CH_ZERO) && (i_char.code <= dstu_pkg::CH_NINE);
    assign is_ws  = (i_char.code == dstu_pkg::CH_SPACE)
                 || ((i_char.code >= dstu_pkg::CH_TAB) && (i_char.code <= dstu_pkg::CH_CR));
    assign digit  = i_char.code[3:0];

    assign wide = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                + {{(WIDE_W-4){1'b0}}, digit};
    assign ovf  = |wide[WIDE_W-1:dstu_pkg::ACC_W];

    always_comb begin
        upd_phase = r_phase;
        upd_acc   = r_acc;
        unique case (r_phase)
            dstu_pkg::PH_LEAD: begin
                if (is_dig) begin
                    upd_acc   = {{(dstu_pkg::ACC_W-4){1'b0}}, digit};
                    upd_phase = dstu_pkg::PH_DIGIT;
                end else if (!is_ws) begin
                    upd_phase = dstu_pkg::PH_FAIL;
                end
            end
            dstu_pkg::PH_DIGIT: begin
                if (is_dig) begin
                    if (ovf) begin
                        upd_phase = dstu_pkg::PH_FAIL;
                    end else begin
                        upd_acc = wide[dstu_pkg::ACC_W-1:0];
                    end
                end else if (is_ws) begin
                    upd_phase = dstu_pkg::PH_TRAIL;
                end else begin
                    upd_phase = dstu_pkg::PH_FAIL;
                end
            end
            dstu_pkg::PH_TRAIL: begin
                if (!is_ws) begin
                    upd_phase = dstu_pkg::PH_FAIL;
                end
            end
            default: begin
                upd_phase = dstu_pkg::PH_FAIL;
            end
        endcase
    end

    always_comb begin
        o_result.ok     = (upd_phase == dstu_pkg::PH_DIGIT) || (upd_phase == dstu_pkg::PH_TRAIL);
        o_result.number = o_result.ok ? upd_acc : '0;
        if (i_char.last) begin
            n_phase = dstu_pkg::PH_LEAD;
            n_acc   = '0;
        end else begin
            n_phase = upd_phase;
            n_acc   = upd_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dstu_pkg::PH_LEAD;
            r_acc   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

endmodule

### sv/decimal_string_to_u64.sv
// ----------------------------------------------------------------------------
// decimal_string_to_u64
// ASCII decimal string to unsigned 64-bit value with format and overflow
// checking; one character per transfer, one result per string.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------
//  input    | i_in_valid / o_in_ready   | i_char_code, i_is_last
//  output   | o_out_valid / i_out_ready | o_ok, o_number
//
//  One character per cycle sustained unless a stall backs up the input; a
//  result is offered once the last character of a string has passed the input
//  and result registers; the shift-add and carry check sit between the two.
//  Synchronous active-low reset empties both registers and returns to the
//  leading whitespace phase. An output stall holds the result and backs up
//  the input only when a further last character needs the result register.
// ----------------------------------------------------------------------------
module decimal_string_to_u64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [63:0] o_number
);

    dstu_pkg::t_char   in_char;
    dstu_pkg::t_char   stg_char;
    dstu_pkg::t_result stg_result;
    dstu_pkg::t_result out_result;
    logic              stg_valid;
    logic              stg_ready;
    logic              res_ready;
    logic              fire;

    assign in_char.code = i_char_code;
    assign in_char.last = i_is_last;

    dstu_pipe_reg #(
        .WIDTH($bits(dstu_pkg::t_char))
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (in_char),
        .o_valid (stg_valid),
        .i_ready (stg_ready),
        .o_data  (stg_char)
    );

    assign stg_ready = !stg_char.last || res_ready;
    assign fire      = stg_valid && stg_ready;

    dstu_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_char   (stg_char),
        .o_result (stg_result)
    );

    dstu_pipe_reg #(
        .WIDTH($bits(dstu_pkg::t_result))
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid && stg_char.last),
        .o_ready (res_ready),
        .i_data  (stg_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_result)
    );

    assign o_ok     = out_result.ok;
    assign o_number = out_result.number;

endmodule

### sv/dstu_checker.sv
// ----------------------------------------------------------------------------
// dstu_checker
// Port-level checks for decimal_string_to_u64, bound to the top level.
// ----------------------------------------------------------------------------
module dstu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_ok,
    input logic [63:0] o_number
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_number == 64'd0))
        else $error("failed parse with nonzero number");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_ok) && $stable(o_number)))
        else $error("stalled result changed");

    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output is taking transfers");

endmodule

bind decimal_string_to_u64 dstu_checker u_dstu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_ok        (o_ok),
    .o_number    (o_number)
);

### bench/decimal_string_to_u64_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_string_to_u64_checker
// Watches both channels of the decimal string parser, predicts each string's
// result from the accepted characters and compares it with the block output.
// ----------------------------------------------------------------------------
module decimal_string_to_u64_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_ok,
    input  logic [63:0] i_number,
    input  logic        i_end_check,
    output int          o_pending,
    output int          o_fail_count
);

    dstu_pkg::t_phase           phase;
    logic [dstu_pkg::ACC_W-1:0] acc;
    dstu_pkg::t_result          parsed_q[$];
    int                         fail_cnt = 0;
    logic                       end_done;

    assign o_fail_count = fail_cnt;

    function automatic logic is_space(input logic [7:0] c);
        return (c == dstu_pkg::CH_SPACE) || (c >= dstu_pkg::CH_TAB && c <= dstu_pkg::CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= dstu_pkg::CH_ZERO) && (c <= dstu_pkg::CH_NINE);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
        fail_cnt++;
    endtask

    // advance the parse by one character; a last character queues a result
    task automatic parse_char(input logic [7:0] c, input logic last);
        logic [dstu_pkg::ACC_W+3:0] wide;
        logic [7:0]                 d;
        dstu_pkg::t_result          r;
        d = c - dstu_pkg::CH_ZERO;
        case (phase)
            dstu_pkg::PH_LEAD: begin
                if (is_digit(c)) begin
                    acc   = (dstu_pkg::ACC_W)'(d);
                    phase = dstu_pkg::PH_DIGIT;
                end else if (!is_space(c)) begin
                    phase = dstu_pkg::PH_FAIL;
                end
            end
            dstu_pkg::PH_DIGIT: begin
                if (is_digit(c)) begin
                    wide = {4'b0, acc} * (dstu_pkg::ACC_W+4)'(10)
                         + (dstu_pkg::ACC_W+4)'(d);
                    if (|wide[dstu_pkg::ACC_W+3:dstu_pkg::ACC_W]) phase = dstu_pkg::PH_FAIL;
                    else acc = wide[dstu_pkg::ACC_W-1:0];
                end else if (is_space(c)) begin
                    phase = dstu_pkg::PH_TRAIL;
                end else begin
                    phase = dstu_pkg::PH_FAIL;
                end
            end
            dstu_pkg::PH_TRAIL: begin
                if (!is_space(c)) phase = dstu_pkg::PH_FAIL;
            end
            default: phase = dstu_pkg::PH_FAIL;
        endcase
        if (last) begin
            r.ok     = (phase == dstu_pkg::PH_DIGIT) || (phase == dstu_pkg::PH_TRAIL);
            r.number = r.ok ? acc : '0;
            parsed_q.push_back(r);
            phase = dstu_pkg::PH_LEAD;
            acc   = '0;
        end
    endtask

    always @(posedge i_clk) begin : p_check
        dstu_pkg::t_result want;
        if (!i_rst_n) begin
            phase    = dstu_pkg::PH_LEAD;
            acc      = '0;
            end_done = 1'b0;
            parsed_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (parsed_q.size() == 0) begin
                    report_mismatch("result with nothing pending", i_number, '0);
                end else begin
                    want = parsed_q.pop_front();
                    if (i_ok !== want.ok) report_mismatch("ok", 64'(i_ok), 64'(want.ok));
                    if (i_number !== want.number)
                        report_mismatch("number", i_number, want.number);
                end
            end
            if (i_in_valid && i_in_ready) parse_char(i_char_code, i_is_last);
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                while (parsed_q.size() != 0) begin
                    want = parsed_q.pop_front();
                    report_mismatch("missing result", '0, want.number);
                end
            end
        end
        o_pending <= parsed_q.size();
    end

endmodule

### bench/decimal_string_to_u64_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_string_to_u64_tb
// Drives character strings into the parser: a few hand-picked strings, then
// random well-formed, boundary, corrupted and noise strings, with bursty input
// and a stalling output. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module decimal_string_to_u64_tb;

    localparam int         N_CHARS     = 1800;
    localparam int         HOLD_CYCLES = 400;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         PAUSE_EVERY = 600;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_VT       = 8'd11;
    localparam logic [7:0] CH_FF       = 8'd12;
    localparam logic [7:0] CH_NUL      = 8'd0;
    localparam logic [7:0] CH_TOP      = 8'd255;
    localparam logic [7:0] CH_X        = 8'd120;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code   = '0;
    logic        is_last     = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        ok;
    logic [63:0] number;
    logic        end_check   = 1'b0;
    int          pending;
    int          fail_count;

    int          burst_left  = 0;
    int          sent_chars  = 0;
    logic        want_hold   = 1'b0;
    logic        hold_done   = 1'b0;
    logic [7:0]  text_q[$];

    decimal_string_to_u64 u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_char_code (char_code),
        .i_is_last   (is_last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_ok        (ok),
        .o_number    (number)
    );

    decimal_string_to_u64_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_char_code  (char_code),
        .i_is_last    (is_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_ok         (ok),
        .i_number     (number),
        .i_end_check  (end_check),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // character source
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        is_last   <= last;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        sent_chars++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // hold the source until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        burst_left = 0;
    endtask

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 5))
            0:       return dstu_pkg::CH_SPACE;
            1:       return dstu_pkg::CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return dstu_pkg::CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_digit();
        return dstu_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic add_spaces(input int n);
        repeat (n) text_q.push_back(rand_space());
    endtask

    task automatic add_value(input logic [67:0] v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic add_well_formed();
        logic [63:0] v;
        int          n;
        add_spaces($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) text_q.push_back(dstu_pkg::CH_ZERO);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 25) : $urandom_range(1, 12);
                repeat (n) text_q.push_back(rand_digit());
            end
            4, 5, 6: begin
                v = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
                add_value(68'(v));
            end
            7:  add_value(68'h0_FFFF_FFFF_FFFF_FFFC + 68'($urandom_range(0, 6)));
            8:  add_value(68'd18446744073709551610 + 68'($urandom_range(0, 9)));
            default: add_value(68'd18446744073709551620 + 68'($urandom_range(0, 9)));
        endcase
        add_spaces($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 10);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0:       text_q.push_back(rand_digit());
                1:       text_q.push_back(rand_space());
                default: text_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic send_directed();
        text_q = '{dstu_pkg::CH_ZERO + 8'd7};
        send_text();
        text_q = '{dstu_pkg::CH_TAB, dstu_pkg::CH_ZERO, dstu_pkg::CH_CR};
        send_text();
        text_q = '{CH_TOP, dstu_pkg::CH_ZERO + 8'd5};
        send_text();
        text_q = '{dstu_pkg::CH_SPACE, dstu_pkg::CH_SPACE};
        send_text();
        text_q = '{CH_NUL};
        send_text();
        text_q = '{dstu_pkg::CH_ZERO + 8'd1, CH_X, dstu_pkg::CH_ZERO + 8'd2};
        send_text();
        text_q = '{dstu_pkg::CH_NINE, dstu_pkg::CH_SPACE, dstu_pkg::CH_NINE};
        send_text();
        text_q = '{CH_LF, CH_VT, dstu_pkg::CH_ZERO + 8'd1, dstu_pkg::CH_ZERO + 8'd2, CH_FF};
        send_text();
    endtask

    initial begin : p_stim
        int kind;
        int pos;
        int next_pause;
        while (!rst_n) @(posedge clk);
        send_directed();
        drain();
        next_pause = PAUSE_EVERY;
        while (sent_chars < N_CHARS) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                add_well_formed();
            end else if (kind < 82) begin
                add_well_formed();
                pos = $urandom_range(0, text_q.size() - 1);
                text_q[pos] = 8'($urandom_range(0, 255));
            end else begin
                add_noise();
            end
            send_text();
            if (sent_chars >= 300) want_hold = 1'b1;
            if (sent_chars >= next_pause) begin
                drain();
                next_pause += PAUSE_EVERY;
            end
        end
        drain();
        repeat (8) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("decimal_string_to_u64 test passed");
        end else begin
            $display("decimal_string_to_u64 test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // result sink
    // ------------------------------------------------------------------------
    initial begin : p_sink
        int mode;
        int len;
        while (!rst_n) @(posedge clk);
        forever begin
            if (want_hold && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(20, 150);
                for (int k = 0; k < len; k++) begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= ($urandom_range(0, 3) != 0);
                        default: out_ready <= ((k % 7) > 2);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles without any transfer
    // ------------------------------------------------------------------------
    initial begin : p_watchdog
        int idle;
        idle = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("decimal_string_to_u64 test failed");
                $finish;
            end
        end
    end

endmodule
